// ----- sv/lcgabs_pkg.sv -----
// Shared types and constants for the LCG additive byte scrambler.
// Used by the controller, the datapath and the top level.
`timescale 1ns / 1ps

package lcgabs_pkg;

	// Generator constants
	localparam logic [31:0] GEN_ADD = 32'd240995;
	localparam logic [31:0] GEN_MUL = 32'd4194301;
	localparam logic [31:0] GEN_MOD = 32'd2147483647;

	// Default bound on record position
	localparam int MAX_RECORD_LEN_DEF = 64;

	// Configuration port
	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 32;
	localparam logic [CFG_IDX_W-1:0] REG_SEED        = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_SIGN_EXTEND = 1'd1;

	// Controller to datapath commands
	typedef struct packed {
		logic load;  // take the input transaction, set up the record position
		logic mul;   // multiply stage of one generator advance
		logic add;   // add, fold and accumulate stage of one advance
		logic emit;  // move the accumulated word into the output register
	} lcgabs_cmd_t;

	// Datapath to controller status
	typedef struct packed {
		logic last;  // the advance in flight is the final one for this byte
	} lcgabs_sts_t;

endpackage

// ----- sv/lcgabs_dp.sv -----
// Datapath of the LCG additive byte scrambler: registers, generator
// step (multiply, then add and fold mod 2^31-1) and accumulator. Uses lcgabs_pkg.
`timescale 1ns / 1ps

module lcgabs_dp
	import lcgabs_pkg::*;
#(
	parameter int MAX_RECORD_LEN = MAX_RECORD_LEN_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_wdata,
	input  logic [7:0]            plain_byte,
	input  logic                  start_req,
	input  lcgabs_cmd_t           cmd,
	output lcgabs_sts_t           sts,
	output logic [31:0]           coded_word
);

	localparam int POS_W = (MAX_RECORD_LEN > 1) ? $clog2(MAX_RECORD_LEN) : 1;
	localparam logic [POS_W-1:0] POS_MAX = POS_W'(MAX_RECORD_LEN - 1);

	logic [31:0]      seed_q;
	logic             sext_q;
	logic [31:0]      gen_q;
	logic [POS_W-1:0] pos_q;
	logic [POS_W-1:0] cnt_q;
	logic [31:0]      prod_q;
	logic [31:0]      acc_q;
	logic [31:0]      out_q;

	logic [POS_W-1:0] pos_use;
	logic [31:0]      byte_ext;
	logic [31:0]      t_sum;
	logic [31:0]      fold;
	logic [31:0]      r_new;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seed_q <= '0;
			sext_q <= 1'b0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_SEED:        seed_q <= cfg_wdata;
				REG_SIGN_EXTEND: sext_q <= cfg_wdata[0];
				default: ;
			endcase
		end
	end

	// Position used by this byte and byte extension
	assign pos_use  = start_req ? '0 : pos_q;
	assign byte_ext = (sext_q && plain_byte[7]) ? {24'hFFFFFF, plain_byte}
	                                            : {24'h000000, plain_byte};

	// t = add + product mod 2^32, then t mod (2^31-1) by folding bit 31
	assign t_sum = prod_q + GEN_ADD;
	assign fold  = {1'b0, t_sum[30:0]} + {31'd0, t_sum[31]};
	assign r_new = (fold >= GEN_MOD) ? (fold - GEN_MOD) : fold;

	// Generator state and position
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gen_q <= '0;
			pos_q <= '0;
		end else if (cmd.load) begin
			if (start_req)
				gen_q <= seed_q;
			pos_q <= (pos_use == POS_MAX) ? pos_use : pos_use + 1'b1;
		end else if (cmd.add) begin
			gen_q <= r_new;
		end
	end

	// Step counter, product, accumulator and output word
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			cnt_q <= pos_use;
			acc_q <= byte_ext;
		end
		if (cmd.mul)
			prod_q <= 32'(gen_q * GEN_MUL);
		if (cmd.add) begin
			acc_q <= acc_q + r_new;
			cnt_q <= cnt_q - 1'b1;
		end
		if (cmd.emit)
			out_q <= acc_q;
	end

	assign sts.last   = (cnt_q == '0);
	assign coded_word = out_q;

	// Folded generator value always lies below the modulus
	a_gen_below_mod: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.add |=> (gen_q < GEN_MOD))
		else $error("generator value not reduced");

	// Step count never exceeds the position bound
	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.mul |-> (cnt_q <= POS_MAX))
		else $error("step count out of range");

	// Position stays within the bound after every byte
	a_pos_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load |=> (pos_q <= POS_MAX))
		else $error("position out of range");

endmodule

// ----- sv/lcgabs_ctrl.sv -----
// Controller of the LCG additive byte scrambler: sequences the generator
// advances for one byte and owns both handshakes. Uses lcgabs_pkg.
`timescale 1ns / 1ps

module lcgabs_ctrl
	import lcgabs_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	output logic        m_tvalid,
	input  logic        m_tready,
	input  lcgabs_sts_t sts,
	output lcgabs_cmd_t cmd
);

	typedef enum logic [1:0] {
		S_IDLE,
		S_MUL,
		S_ADD,
		S_HOLD
	} state_t;

	state_t state_q;
	logic   m_tvalid_q;
	logic   out_free;

	assign out_free = !m_tvalid_q || m_tready;

	// Commands decoded from state
	always_comb begin
		cmd      = '0;
		cmd.load = (state_q == S_IDLE) && s_tvalid;
		cmd.mul  = (state_q == S_MUL);
		cmd.add  = (state_q == S_ADD);
		cmd.emit = (state_q == S_HOLD) && out_free;
	end

	assign s_tready = (state_q == S_IDLE);
	assign m_tvalid = m_tvalid_q;

	// State and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			m_tvalid_q <= 1'b0;
		end else begin
			unique case (state_q)
				S_IDLE: if (s_tvalid) state_q <= S_MUL;
				S_MUL:  state_q <= S_ADD;
				S_ADD:  state_q <= sts.last ? S_HOLD : S_MUL;
				S_HOLD: if (out_free) state_q <= S_IDLE;
				default: state_q <= S_IDLE;
			endcase
			// a new word sets valid, a taken word clears it
			if (cmd.emit)
				m_tvalid_q <= 1'b1;
			else if (m_tvalid_q && m_tready)
				m_tvalid_q <= 1'b0;
		end
	end

	// A new word never overwrites one still waiting
	a_emit_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit |-> (!m_tvalid || m_tready))
		else $error("output overwritten");

	// At most one command at a time
	a_cmd_onehot: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0(cmd))
		else $error("overlapping commands");

	// After an accepted transaction the input side closes
	a_busy_after_load: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready) |=> !s_tready)
		else $error("input accepted while busy");

endmodule

// ----- sv/lcg_additive_byte_scrambler.sv -----
// Top level of the LCG additive byte scrambler.
// Joins lcgabs_ctrl and lcgabs_dp; uses lcgabs_pkg.
`timescale 1ns / 1ps

// Each input byte becomes one 32-bit word: the byte (sign- or zero-extended)
// plus every generator value made for it, mod 2^32. A transaction with
// s_tuser set starts a record: the generator reloads from the seed register
// and the position goes to zero. The byte at position i reaches the output
// register after its generator advances, and the next byte can be accepted
// once its word is in the output register, because the generator
// advances serially through one shared multiplier and one add-and-fold stage
// per step; one byte is in work at a time. Position saturates at
// MAX_RECORD_LEN-1. The output register lets the next byte be accepted while
// a finished word waits. Configuration must be written only while the block
// is idle; the block itself does not enforce it.
module lcg_additive_byte_scrambler
	import lcgabs_pkg::*;
#(
	parameter int MAX_RECORD_LEN = MAX_RECORD_LEN_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,  // 0 seed, 1 sign_extend
	input  logic [CFG_DATA_W-1:0] cfg_wdata,
	input  logic                  s_tvalid,
	output logic                  s_tready,
	input  logic [7:0]            s_tdata,    // [7:0] plain_byte
	input  logic                  s_tuser,    // [0] start_req
	output logic                  m_tvalid,
	input  logic                  m_tready,
	output logic [31:0]           m_tdata     // [31:0] coded_word
);

	lcgabs_cmd_t cmd;
	lcgabs_sts_t sts;

	lcgabs_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	lcgabs_dp #(
		.MAX_RECORD_LEN (MAX_RECORD_LEN)
	) u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_wdata  (cfg_wdata),
		.plain_byte (s_tdata),
		.start_req  (s_tuser),
		.cmd        (cmd),
		.sts        (sts),
		.coded_word (m_tdata)
	);

endmodule

// ----- sim/testbench.sv -----
// Self-checking testbench for lcg_additive_byte_scrambler: random and directed
// byte records against a built-in predictor. Uses lcgabs_pkg.
`timescale 1ns / 1ps

module testbench;
	import lcgabs_pkg::*;

	localparam int MAX_REC       = 64;
	localparam int SETTLE_CYCLES = 2 * (MAX_REC + 1) + 8;  // slowest byte, plus margin
	localparam int STALL_LIMIT   = 4000;                   // cycles with no transaction
	localparam int HOLD_CYCLES   = 300;                    // long receiver hold-off
	localparam int PHASE_ITEMS   = 200;

	// Predictor of the scrambled words and the queue of words still owed
	class coded_word_board;
		logic [31:0] seed_reg;
		bit          sign_ext_reg;
		logic [31:0] gen_value;
		int          rec_pos;
		int          rec_bound;
		logic [31:0] owed_words[$];
		int          mismatches;

		function new(int bound);
			rec_bound    = bound;
			seed_reg     = '0;
			sign_ext_reg = 1'b0;
			gen_value    = '0;
			rec_pos      = 0;
			mismatches   = 0;
		endfunction

		function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] value);
			if (idx == REG_SEED)
				seed_reg = value;
			else if (idx == REG_SIGN_EXTEND)
				sign_ext_reg = value[0];
		endfunction

		// one generator step: 32-bit wrap, then fold by 2^31-1
		function logic [31:0] next_gen(logic [31:0] r);
			logic [31:0] t;
			t = 32'd240995 + 32'd4194301 * r;
			return t % 32'd2147483647;
		endfunction

		// accepted input byte: work out the word it must produce
		function void note_byte(logic [7:0] plain, bit start);
			logic [31:0] acc;
			logic [31:0] r;
			if (start) begin
				gen_value = seed_reg;
				rec_pos   = 0;
			end
			acc = (sign_ext_reg && plain[7]) ? {24'hFF_FFFF, plain} : {24'h0, plain};
			r = gen_value;
			for (int k = 0; k <= rec_pos; k++) begin
				r = next_gen(r);
				acc += r;
			end
			gen_value = r;
			if (rec_pos < rec_bound - 1)
				rec_pos++;
			owed_words.push_back(acc);
		endfunction

		// accepted output word: compare with the oldest owed word
		function void check_word(logic [31:0] word);
			logic [31:0] want;
			if (owed_words.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("ERROR: unexpected word %h", word);
				return;
			end
			want = owed_words.pop_front();
			if (word !== want) begin
				mismatches++;
				if (mismatches <= 10)
					$display("ERROR: coded_word expected %h, got %h", want, word);
			end
		endfunction

		function int pending();
			return owed_words.size();
		endfunction
	endclass

	logic                  clk       = 1'b0;
	logic                  arst_n    = 1'b0;
	logic                  cfg_we    = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_wdata = '0;
	logic                  s_tvalid  = 1'b0;
	logic                  s_tready;
	logic [7:0]            s_tdata   = '0;
	logic                  s_tuser   = 1'b0;
	logic                  m_tvalid;
	logic                  m_tready  = 1'b0;
	logic [31:0]           m_tdata;

	coded_word_board board;
	bit tx_calm       = 1'b0;
	int words_seen    = 0;
	int hold_left     = 0;
	bit hold_done     = 1'b0;
	int quiet_cycles  = 0;

	lcg_additive_byte_scrambler #(
		.MAX_RECORD_LEN(MAX_REC)
	) DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_wdata(cfg_wdata),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),    // [7:0] plain_byte
		.s_tuser  (s_tuser),    // [0] start_req
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)     // [31:0] coded_word
	);

	initial begin
		forever #1 clk = ~clk;
	end

	// Receiver: random back-pressure, one long hold-off, one calm stretch
	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) begin
			board.check_word(m_tdata);
			words_seen++;
		end
		if (hold_left > 0) begin
			hold_left--;
			m_tready <= 1'b0;
		end else if (!hold_done && words_seen >= 100) begin
			hold_done = 1'b1;
			hold_left = HOLD_CYCLES;
			m_tready  <= 1'b0;
		end else if (words_seen >= 400 && words_seen < 550) begin
			m_tready <= 1'b1;
		end else begin
			m_tready <= ($urandom_range(0, 99) >= 34);
		end
	end

	// Watchdog on cycles without any transaction
	always @(posedge clk) begin
		if (arst_n) begin
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
				quiet_cycles = 0;
			else
				quiet_cycles++;
			if (quiet_cycles >= STALL_LIMIT) begin
				$display("ERROR: no transaction for %0d cycles", STALL_LIMIT);
				$display("*** FAILED ***");
				$finish;
			end
		end
	end

	// Offer one byte, with random gaps ahead of it, and wait for acceptance
	task automatic send_byte(input logic [7:0] plain, input bit start);
		while (!tx_calm && $urandom_range(0, 99) < 34) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= plain;
		s_tuser  <= start;
		do @(posedge clk); while (!s_tready);
		board.note_byte(plain, start);
	endtask

	// Stop offering and wait for every owed word
	task automatic drain_block();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (board.pending() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	// Write both registers; upper bits of the flag write are noise
	task automatic write_regs(input logic [31:0] seed, input bit sign_ext);
		logic [31:0] flag_word;
		flag_word = ($urandom() & 32'hFFFF_FFFE) | {31'd0, sign_ext};
		cfg_we    <= 1'b1;
		cfg_index <= REG_SEED;
		cfg_wdata <= seed;
		@(posedge clk);
		board.set_reg(REG_SEED, seed);
		cfg_index <= REG_SIGN_EXTEND;
		cfg_wdata <= flag_word;
		@(posedge clk);
		board.set_reg(REG_SIGN_EXTEND, flag_word);
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	initial begin
		int sent;
		int rec_len;
		bit open_rec;
		board = new(MAX_REC);
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset register values, bytes before any record start
		send_byte(8'h00, 1'b0);
		send_byte(8'hFF, 1'b0);
		send_byte(8'h80, 1'b0);
		send_byte(8'h7F, 1'b1);
		send_byte(8'h01, 1'b0);
		drain_block();

		// all-ones seed, signed bytes, restart in mid-record
		write_regs(32'hFFFF_FFFF, 1'b1);
		send_byte(8'h80, 1'b1);
		send_byte(8'hFF, 1'b0);
		send_byte(8'h7F, 1'b0);
		send_byte(8'h00, 1'b0);
		send_byte(8'hAA, 1'b0);
		send_byte(8'h55, 1'b1);
		send_byte(8'hFE, 1'b0);
		send_byte(8'h81, 1'b0);
		drain_block();

		// zero seed, unsigned bytes
		write_regs(32'h0, 1'b0);
		send_byte(8'hFF, 1'b1);
		send_byte(8'h80, 1'b0);
		send_byte(8'h00, 1'b1);
		send_byte(8'h7F, 1'b0);
		drain_block();

		// random records; a few run past the position bound
		for (int ph = 0; ph < 4; ph++) begin
			write_regs($urandom(), ph[0]);
			tx_calm = (ph == 1);
			sent = 0;
			while (sent < PHASE_ITEMS) begin
				if (ph == 0 && sent == 0)
					rec_len = MAX_REC + 2;
				else if ($urandom_range(0, 9) == 0)
					rec_len = $urandom_range(MAX_REC - 4, MAX_REC + 8);
				else
					rec_len = $urandom_range(1, 40);
				// occasionally a record continues without its start mark
				open_rec = ($urandom_range(0, 11) != 0);
				for (int k = 0; k < rec_len; k++) begin
					send_byte(8'($urandom_range(0, 255)),
						(k == 0 && open_rec) || ($urandom_range(0, 59) == 0));
					sent++;
				end
			end
			tx_calm = 1'b0;
			drain_block();
		end

		repeat (SETTLE_CYCLES) @(posedge clk);
		if (board.pending() != 0)
			$display("ERROR: %0d words never arrived", board.pending());
		if (board.mismatches == 0 && board.pending() == 0) begin
			$display("*** PASSED ***");
		end else begin
			$display("*** FAILED ***");
		end
		$finish;
	end

endmodule

// ----- lcg_additive_byte_scrambler.f -----
sv/lcgabs_pkg.sv
sv/lcgabs_dp.sv
sv/lcgabs_ctrl.sv
sv/lcg_additive_byte_scrambler.sv
sim/testbench.sv
